@@ sv/spi_register_frame_slave_unit_defines.svh @@
// ----------------------------------------------------------------------------
// SPI register frame slave: assertion macros
// Concurrent assertion helpers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SPI_REGISTER_FRAME_SLAVE_UNIT_DEFINES_SVH
`define SPI_REGISTER_FRAME_SLAVE_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define SRFS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("srfs implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SRFS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("srfs next-cycle check failed");

`else

`define SRFS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SRFS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ sv/srfs_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI register frame slave: package
// Register map, fixed values, flag positions and shared types.
// ----------------------------------------------------------------------------
package srfs_pkg;

  // Operation codes of an input transaction.
  localparam logic OpFrame  = 1'b0;
  localparam logic OpResync = 1'b1;

  // Command byte layout.
  localparam int unsigned CmdWriteBit = 7;
  localparam int unsigned AddrWidth   = 7;

  // Register addresses.
  localparam logic [AddrWidth-1:0] AddrDeviceId  = 7'h00;
  localparam logic [AddrWidth-1:0] AddrFwVersion = 7'h01;
  localparam logic [AddrWidth-1:0] AddrStatus    = 7'h02;
  localparam logic [AddrWidth-1:0] AddrControl   = 7'h03;
  localparam logic [AddrWidth-1:0] AddrRate      = 7'h04;
  localparam logic [AddrWidth-1:0] AddrNop       = 7'h7F;

  // Fixed register contents.
  localparam logic [31:0] DeviceIdVal  = 32'hAC00_ACC0;
  localparam logic [31:0] FwVersionVal = 32'h0001_0200;

  // Sample rate register.
  localparam int unsigned  RateWidth = 14;
  localparam logic [31:0]  RateMax   = 32'd10000;
  localparam logic [RateWidth-1:0] RateReset = 14'd1000;

  // Control register bits.
  localparam int unsigned CtrlRunBit   = 0;
  localparam int unsigned CtrlClearBit = 1;

  // Status flag positions.
  localparam int unsigned FlagWidth    = 4;
  localparam int unsigned FlagRun      = 0;
  localparam int unsigned FlagCmdErr   = 1;
  localparam int unsigned FlagRangeErr = 2;
  localparam int unsigned FlagResync   = 3;

  // One input item as held in the input register.
  typedef struct packed {
    logic        operation;
    logic [7:0]  command_byte;
    logic [31:0] write_word;
  } in_item_t;

  // Access request from the pipeline to the register file.
  typedef struct packed {
    logic                 fire;
    logic                 resync;
    logic                 write;
    logic [AddrWidth-1:0] addr;
    logic [31:0]          wdata;
  } req_t;

endpackage

@@ sv/srfs_in_if.sv @@
// ----------------------------------------------------------------------------
// SPI register frame slave: input channel
// Valid/ready channel carrying one received frame or resync event.
// ----------------------------------------------------------------------------
interface srfs_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  command_byte;
  logic [31:0] write_word;

  modport source (output valid, output operation, output command_byte,
                  output write_word, input ready);
  modport sink   (input valid, input operation, input command_byte,
                  input write_word, output ready);
endinterface

@@ sv/srfs_out_if.sv @@
// ----------------------------------------------------------------------------
// SPI register frame slave: output channel
// Valid/ready channel carrying one reply for the next frame.
// ----------------------------------------------------------------------------
interface srfs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reply_command;
  logic [31:0] reply_word;

  modport source (output valid, output reply_command, output reply_word,
                  input ready);
  modport sink   (input valid, input reply_command, input reply_word,
                  output ready);
endinterface

@@ sv/srfs_regfile.sv @@
// ----------------------------------------------------------------------------
// SPI register frame slave: register file
// Holds status, run and sample rate; decodes one access per cycle.
// ----------------------------------------------------------------------------
module srfs_regfile (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srfs_pkg::req_t req_i,
  output logic [31:0]    rdata_o
);
  import srfs_pkg::*;

  logic [FlagWidth-1:0] status_q, status_d;
  logic                 run_q, run_d;
  logic [RateWidth-1:0] rate_q, rate_d;
  logic                 rate_ok;

  assign rate_ok = (|req_i.wdata) && (req_i.wdata <= RateMax);

  always_comb begin
    status_d = status_q;
    run_d    = run_q;
    rate_d   = rate_q;
    rdata_o  = '0;
    if (req_i.fire) begin
      if (req_i.resync) begin
        status_d[FlagResync] = 1'b1;
      end else if (req_i.write) begin
        unique case (req_i.addr)
          AddrControl: begin
            if (req_i.wdata[CtrlClearBit]) begin
              status_d[FlagCmdErr]   = 1'b0;
              status_d[FlagRangeErr] = 1'b0;
              status_d[FlagResync]   = 1'b0;
            end
            run_d              = req_i.wdata[CtrlRunBit];
            status_d[FlagRun]  = req_i.wdata[CtrlRunBit];
          end
          AddrRate: begin
            if (rate_ok) begin
              rate_d = req_i.wdata[RateWidth-1:0];
            end else begin
              status_d[FlagRangeErr] = 1'b1;
            end
          end
          default: begin
            status_d[FlagCmdErr] = 1'b1;
          end
        endcase
      end else begin
        unique case (req_i.addr)
          AddrDeviceId:  rdata_o = DeviceIdVal;
          AddrFwVersion: rdata_o = FwVersionVal;
          AddrStatus:    rdata_o = {{(32-FlagWidth){1'b0}}, status_q};
          AddrControl:   rdata_o = {31'b0, run_q};
          AddrRate:      rdata_o = {{(32-RateWidth){1'b0}}, rate_q};
          AddrNop:       rdata_o = '0;
          default: begin
            status_d[FlagCmdErr] = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      run_q    <= 1'b0;
      rate_q   <= RateReset;
    end else begin
      status_q <= status_d;
      run_q    <= run_d;
      rate_q   <= rate_d;
    end
  end

endmodule

@@ sv/spi_register_frame_slave_unit.sv @@
// ----------------------------------------------------------------------------
// SPI register frame slave unit
// Register file served by 5-byte SPI frames: decodes one frame per cycle while out_o is not stalled, and
// produces the reply that is shifted out during the following frame.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake    Payload
// in_i      sink       valid/ready  operation, command_byte, write_word
// out_o     source     valid/ready  reply_command, reply_word
//
// A transaction is registered in the input stage, then decoded against the
// register file once the output register is free and its reply written to the
// output register, which presents it on out_o. One transaction per cycle is
// sustained while out_o is not stalled; the input stage and the output register
// together set that rate.
// A resync event updates the flags and produces no reply, so it never waits on
// out_o. Reset (rst_ni, asynchronous) clears the flags and run bit and loads a
// sample rate of 1000. A stalled out_o holds the reply and fills the input
// stage before in_i.ready drops.

`include "spi_register_frame_slave_unit_defines.svh"

module spi_register_frame_slave_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  srfs_in_if.sink   in_i,
  srfs_out_if.source out_o
);
  import srfs_pkg::*;

  // Input stage.
  logic     s1_valid_q;
  in_item_t s1_q;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_cmd_q;
  logic [31:0] out_word_q;

  logic        out_free;
  logic        s1_adv;
  logic        s1_is_resync;
  logic        in_ready;
  logic        reply_load;
  req_t        req;
  logic [31:0] rdata;

  // The output register can take a new reply when it is empty or being drained
  // in this cycle. A resync in the input stage always moves on, since it has
  // no reply to deposit.
  assign s1_is_resync = (s1_q.operation == OpResync);
  assign out_free     = !out_valid_q || out_o.ready;
  assign s1_adv       = s1_valid_q && (s1_is_resync || out_free);
  assign reply_load   = s1_adv && !s1_is_resync;
  assign in_ready     = !s1_valid_q || s1_adv;
  assign in_i.ready   = in_ready;

  // The register file sees the held item exactly in the cycle it leaves the
  // input stage, which keeps state updates in acceptance order.
  always_comb begin
    req.fire   = s1_adv;
    req.resync = s1_is_resync;
    req.write  = s1_q.command_byte[CmdWriteBit];
    req.addr   = s1_q.command_byte[AddrWidth-1:0];
    req.wdata  = s1_q.write_word;
  end

  srfs_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rdata_o(rdata)
  );

  // Control flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= reply_load;
      end
    end
  end

  // Payload flops; they load only alongside a valid transaction.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      s1_q.operation    <= in_i.operation;
      s1_q.command_byte <= in_i.command_byte;
      s1_q.write_word   <= in_i.write_word;
    end
    if (reply_load) begin
      out_cmd_q  <= s1_q.command_byte;
      out_word_q <= rdata;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.reply_command = out_cmd_q;
  assign out_o.reply_word    = out_word_q;

  // A frame leaving the input stage always lands a reply in the output register.
  `SRFS_ASSERT_NXT(a_frame_gives_reply, clk_i, rst_ni, reply_load, out_valid_q)
  // Replies to writes carry a zero data word.
  `SRFS_ASSERT_IMP(a_write_reply_zero, clk_i, rst_ni,
                   out_valid_q && out_cmd_q[CmdWriteBit], out_word_q == 32'b0)
  // Back-pressure on the input only arises from a held item that cannot move.
  `SRFS_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready,
                   s1_valid_q && !s1_is_resync && out_valid_q && !out_o.ready)

endmodule

@@ dv/srfs_reply_checker.sv @@
// ----------------------------------------------------------------------------
// SPI register frame slave: reply checker
// Watches both channels, keeps its own copy of the register file and compares
// every reply with the one that the accepted frame should have produced.
// ----------------------------------------------------------------------------
module srfs_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  srfs_in_if          in_mon,
  srfs_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned replies_due_o
);
  import srfs_pkg::*;

  typedef struct packed {
    logic [7:0]  command;
    logic [31:0] word;
  } reply_t;

  // Register file as the block should hold it.
  logic [FlagWidth-1:0] status_q;
  logic                 run_q;
  logic [RateWidth-1:0] rate_q;

  reply_t      replies_due[$];
  int unsigned fail_count;

  assign fail_count_o  = fail_count;
  assign replies_due_o = replies_due.size();

  // Applies one received frame to the register file and returns its reply word.
  function automatic logic [31:0] apply_frame(input logic [7:0] cmd, input logic [31:0] word);
    logic [AddrWidth-1:0] addr;
    logic [31:0]          rdata;
    addr  = cmd[AddrWidth-1:0];
    rdata = '0;
    if (cmd[CmdWriteBit]) begin
      case (addr)
        AddrControl: begin
          if (word[CtrlClearBit]) begin
            status_q[FlagCmdErr]   = 1'b0;
            status_q[FlagRangeErr] = 1'b0;
            status_q[FlagResync]   = 1'b0;
          end
          run_q             = word[CtrlRunBit];
          status_q[FlagRun] = word[CtrlRunBit];
        end
        AddrRate: begin
          // The lowest legal rate is one; zero is rejected like any overflow.
          if (word >= 32'd1 && word <= RateMax) begin
            rate_q = word[RateWidth-1:0];
          end else begin
            status_q[FlagRangeErr] = 1'b1;
          end
        end
        default: status_q[FlagCmdErr] = 1'b1;
      endcase
    end else begin
      case (addr)
        AddrDeviceId:  rdata = DeviceIdVal;
        AddrFwVersion: rdata = FwVersionVal;
        AddrStatus:    rdata = 32'(status_q);
        AddrControl:   rdata = 32'(run_q);
        AddrRate:      rdata = 32'(rate_q);
        AddrNop:       rdata = '0;
        default:       status_q[FlagCmdErr] = 1'b1;
      endcase
    end
    return rdata;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      status_q = '0;
      run_q    = 1'b0;
      rate_q   = RateReset;
      replies_due.delete();
      fail_count = 0;
    end else begin
      // A reply leaves only after its frame has passed the input stage and the
      // output register, so the output side is handled first without any risk of overtaking.
      if (out_mon.valid && out_mon.ready) begin
        got.command = out_mon.reply_command;
        got.word    = out_mon.reply_word;
        if (replies_due.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected reply: command %02h word %08h", got.command, got.word);
          end
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (got.command !== want.command) begin
            if (fail_count < 10) begin
              $display("reply_command mismatch: expected %02h actual %02h",
                       want.command, got.command);
            end
            fail_count++;
          end
          if (got.word !== want.word) begin
            if (fail_count < 10) begin
              $display("reply_word mismatch (command %02h): expected %08h actual %08h",
                       want.command, want.word, got.word);
            end
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OpResync) begin
          status_q[FlagResync] = 1'b1;
        end else begin
          want.command = in_mon.command_byte;
          want.word    = apply_frame(in_mon.command_byte, in_mon.write_word);
          replies_due.push_back(want);
        end
      end
    end
  end

endmodule

@@ dv/tb_spi_register_frame_slave_unit.sv @@
// ----------------------------------------------------------------------------
// SPI register frame slave unit: testbench
// Sends directed and random frames and resync events through the input
// channel while the reply channel stalls on its own pattern; a checker beside
// the block predicts every reply and counts mismatches.
// ----------------------------------------------------------------------------
module tb_spi_register_frame_slave_unit;
  import srfs_pkg::*;

  localparam int unsigned RandomFrames = 1350;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned replies_due;

  // Number of transactions left in the current sender burst.
  int unsigned burst_left;

  srfs_in_if  in_if ();
  srfs_out_if out_if ();

  spi_register_frame_slave_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  srfs_reply_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .fail_count_o  (fail_count),
    .replies_due_o (replies_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Offers one transaction and returns at the edge where it is accepted. The
  // sender works in bursts; between bursts it drops valid for a random gap.
  // Most gaps are short, a few are long, and some bursts run for up to 250
  // transactions so that back-to-back traffic is covered as well.
  task automatic send_item(input logic op, input logic [7:0] cmd, input logic [31:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 250)
                                               : $urandom_range(1, 12);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.command_byte <= cmd;
    in_if.write_word   <= word;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // Builds one random transaction. Most are frames to the defined registers
  // with random content, since only those can clear the flags or move the run bit and rate;
  // the rest are resync events and frames to arbitrary addresses.
  task automatic next_random_item(output logic op, output logic [7:0] cmd,
                                  output logic [31:0] word);
    int unsigned          pick;
    logic                 wr;
    logic [AddrWidth-1:0] addr;
    pick = $urandom_range(0, 99);
    wr   = 1'($urandom_range(0, 1));
    word = $urandom;
    op   = OpFrame;
    if (pick < 8) begin
      // Command and word of a resync event are don't-cares; keep them random.
      op   = OpResync;
      addr = AddrWidth'($urandom);
    end else if (pick < 22) begin
      addr = AddrWidth'($urandom);
    end else begin
      case ($urandom_range(0, 8))
        0:       addr = AddrDeviceId;
        1:       addr = AddrFwVersion;
        2, 3:    addr = AddrStatus;
        4, 5:    addr = AddrControl;
        6, 7:    addr = AddrRate;
        default: addr = AddrNop;
      endcase
      if (wr && addr == AddrControl) begin
        // Keep the clear bit rare so that error flags can pile up in between.
        word[CtrlClearBit] = ($urandom_range(0, 3) == 0);
      end else if (wr && addr == AddrRate) begin
        case ($urandom_range(0, 4))
          0, 1: word = $urandom_range(1, RateMax);
          2: begin
            case ($urandom_range(0, 3))
              0:       word = 32'd0;
              1:       word = 32'd1;
              2:       word = RateMax;
              default: word = RateMax + 32'd1;
            endcase
          end
          3:       word = $urandom_range(1, 16383);
          default: word = $urandom;
        endcase
      end
    end
    cmd = {wr, addr};
  endtask

  // Receiver: the ready pattern switches between always ready, a random coin
  // and a mostly stalled mode, each for a random number of cycles.
  initial begin : reply_sink
    int unsigned stall_mode;
    int unsigned span;
    out_if.ready <= 1'b0;
    stall_mode = 0;
    span       = 0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        stall_mode = $urandom_range(0, 2);
        span       = $urandom_range(10, 150);
      end
      span--;
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin : stimulus
    logic        op;
    logic [7:0]  cmd;
    logic [31:0] word;
    int unsigned settle;

    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.operation    <= OpFrame;
    in_if.command_byte <= '0;
    in_if.write_word   <= '0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reads right after reset show the reset contents of every
    // register, including a rate of 1000 and all flags clear.
    send_item(OpFrame, {1'b0, AddrDeviceId}, 32'hFFFF_FFFF);
    send_item(OpFrame, {1'b0, AddrFwVersion}, '0);
    send_item(OpFrame, {1'b0, AddrStatus}, '0);
    send_item(OpFrame, {1'b0, AddrControl}, '0);
    send_item(OpFrame, {1'b0, AddrRate}, '0);
    send_item(OpFrame, {1'b0, AddrNop}, '0);
    // Reading an unknown address raises the command error.
    send_item(OpFrame, {1'b0, 7'h05}, '0);
    send_item(OpFrame, {1'b0, 7'h7E}, '0);
    send_item(OpFrame, {1'b0, AddrStatus}, '0);
    // Writes to read-only, no-op and unknown addresses are refused.
    send_item(OpFrame, {1'b1, AddrDeviceId}, 32'hFFFF_FFFF);
    send_item(OpFrame, {1'b1, AddrStatus}, 32'hFFFF_FFFF);
    send_item(OpFrame, {1'b1, AddrNop}, 32'h1234_5678);
    send_item(OpFrame, {1'b1, 7'h40}, '0);
    // Sample rate at and beyond both ends of its legal range.
    send_item(OpFrame, {1'b1, AddrRate}, 32'd0);
    send_item(OpFrame, {1'b1, AddrRate}, 32'd1);
    send_item(OpFrame, {1'b1, AddrRate}, RateMax);
    send_item(OpFrame, {1'b1, AddrRate}, RateMax + 32'd1);
    send_item(OpFrame, {1'b1, AddrRate}, 32'hFFFF_FFFF);
    send_item(OpFrame, {1'b0, AddrRate}, '0);
    // A resync event carries don't-care fields, here all ones, and gives no
    // reply.
    send_item(OpResync, 8'hFF, 32'hFFFF_FFFF);
    send_item(OpFrame, {1'b0, AddrStatus}, '0);
    // Control: set run with every other bit high (clear included), then stop
    // without clearing, then clear alone.
    send_item(OpFrame, {1'b1, AddrControl}, 32'hFFFF_FFFF);
    send_item(OpFrame, {1'b0, AddrStatus}, '0);
    send_item(OpFrame, {1'b1, AddrControl}, 32'h0000_0000);
    send_item(OpFrame, {1'b1, AddrControl}, 32'h0000_0002);

    repeat (RandomFrames) begin
      next_random_item(op, cmd, word);
      send_item(op, cmd, word);
    end
    in_if.valid <= 1'b0;

    // Wait until the checker has recorded the last transaction, let every
    // outstanding reply drain, then let the pipeline settle so that a stray
    // reply would still be caught.
    @(posedge clk_i);
    while (replies_due != 0) @(posedge clk_i);
    settle = 10;
    repeat (settle) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/srfs_pkg.sv
sv/srfs_in_if.sv
sv/srfs_out_if.sv
sv/srfs_regfile.sv
sv/spi_register_frame_slave_unit.sv
dv/srfs_reply_checker.sv
dv/tb_spi_register_frame_slave_unit.sv
